FILE: design/sts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted timetable search
// Payload structs, status and mode codes, and the ctrl/datapath command set.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned MAX_STOPS_DEF = 32;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_COL  = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_STOP = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] time_value;
    logic [4:0]  from_stop;
    logic [4:0]  to_stop;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_time;
    logic        found;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_COUNT
  } idx_op_e;

  typedef enum logic [1:0] {
    ROW_IDX, ROW_IDXM1, ROW_POS
  } row_sel_e;

  typedef enum logic [1:0] {
    COL_FROM, COL_TO, COL_ZERO, COL_STP
  } col_sel_e;

  typedef enum logic [1:0] {
    RES_HOLD, RES_STATUS, RES_HIT
  } res_op_e;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_RES, OUT_COL
  } out_op_e;

  typedef struct packed {
    logic       latch;
    logic       add_time;
    idx_op_e    idx_op;
    logic       stp_zero;
    logic       stp_inc;
    logic       pos_load;
    logic       rd_en;
    logic       wr_en;
    logic       wr_buf;
    row_sel_e   row_sel;
    col_sel_e   col_sel;
    logic       cnt_inc;
    res_op_e    res_op;
    logic [1:0] res_status;
    out_op_e    out_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bad_col;
    logic       bad_find;
    logic       empty;
    logic       full;
    logic       row_done;
    logic       ge_hit;
    logic       lt_first;
    logic       idx_at_count;
    logic       idx_at_last;
    logic       idx_at_pos;
    logic       stp_end;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/sts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ctrl: sequencer for the timetable search
// One-hot FSM issuing datapath commands for add, column read and find.
// ----------------------------------------------------------------------------
module sts_ctrl
  import sts_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_EMIT     = 13'b0000000000100,
    S_COL_RD   = 13'b0000000001000,
    S_COL_OUT  = 13'b0000000010000,
    S_FIND_RD  = 13'b0000000100000,
    S_FIND_CMP = 13'b0000001000000,
    S_FIND_GET = 13'b0000010000000,
    S_POS_RD   = 13'b0000100000000,
    S_POS_CMP  = 13'b0001000000000,
    S_SH_RD    = 13'b0010000000000,
    S_SH_WR    = 13'b0100000000000,
    S_ROW_WR   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_op  = IDX_HOLD;
    cmd_o.row_sel = ROW_IDX;
    cmd_o.col_sel = COL_FROM;
    cmd_o.res_op  = RES_HOLD;
    cmd_o.out_op  = OUT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_op = RES_STATUS;
        priority case (stat_i.mode)
          MODE_ADD: begin
            cmd_o.add_time   = 1'b1;
            cmd_o.res_status = ST_OK;
            if (stat_i.row_done && stat_i.full) begin
              cmd_o.res_status = ST_FULL;
              state_d          = S_EMIT;
            end else if (stat_i.row_done) begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_POS_RD;
            end else begin
              state_d = S_EMIT;
            end
          end
          MODE_COL: begin
            if (stat_i.bad_col) begin
              cmd_o.res_status = ST_BAD_STOP;
              state_d          = S_EMIT;
            end else if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_EMIT;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_COL_RD;
            end
          end
          MODE_FIND: begin
            if (stat_i.bad_find) begin
              cmd_o.res_status = ST_BAD_STOP;
              state_d          = S_EMIT;
            end else if (stat_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_EMIT;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_FIND_RD;
            end
          end
          default: state_d = S_IDLE;   // unused mode: no beat
        endcase
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_op = OUT_RES;
          state_d      = S_IDLE;
        end
      end
      S_COL_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_COL_OUT;
      end
      S_COL_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_op = OUT_COL;
          if (stat_i.idx_at_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_COL_RD;
          end
        end
      end
      S_FIND_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (stat_i.ge_hit) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.col_sel = COL_TO;
          state_d       = S_FIND_GET;
        end else if (stat_i.idx_at_last) begin
          cmd_o.res_op     = RES_STATUS;
          cmd_o.res_status = ST_OK;
          state_d          = S_EMIT;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_FIND_RD;
        end
      end
      S_FIND_GET: begin
        cmd_o.res_op = RES_HIT;
        state_d      = S_EMIT;
      end
      S_POS_RD: begin
        if (stat_i.idx_at_count) begin
          cmd_o.pos_load = 1'b1;
          cmd_o.idx_op   = IDX_COUNT;
          cmd_o.stp_zero = 1'b1;
          state_d        = S_SH_RD;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.col_sel = COL_ZERO;
          state_d       = S_POS_CMP;
        end
      end
      S_POS_CMP: begin
        if (stat_i.lt_first) begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_POS_RD;
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.idx_op   = IDX_COUNT;
          cmd_o.stp_zero = 1'b1;
          state_d        = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.idx_at_pos) begin
          cmd_o.stp_zero = 1'b1;
          state_d        = S_ROW_WR;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.row_sel = ROW_IDXM1;
          cmd_o.col_sel = COL_STP;
          state_d       = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.col_sel = COL_STP;
        if (stat_i.stp_end) begin
          cmd_o.stp_zero = 1'b1;
          cmd_o.idx_op   = IDX_DEC;
        end else begin
          cmd_o.stp_inc = 1'b1;
        end
        state_d = S_SH_RD;
      end
      S_ROW_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_buf  = 1'b1;
        cmd_o.row_sel = ROW_POS;
        cmd_o.col_sel = COL_STP;
        if (stat_i.stp_end) begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_EMIT;
        end else begin
          cmd_o.stp_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/sts_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_dpath: timetable datapath
// Time table memory, row buffer, counters, compares and the output register.
// ----------------------------------------------------------------------------
module sts_dpath
  import sts_pkg::*;
#(
  parameter int unsigned MaxRows  = MAX_ROWS_DEF,
  parameter int unsigned MaxStops = MAX_STOPS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [5:0] cfg_data_i,
  input  wire in_item_t in_data_i,
  input  wire cmd_t     cmd_i,
  output stat_t         stat_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  localparam int unsigned SW    = (MaxStops > 1) ? $clog2(MaxStops) : 1;
  localparam int unsigned CW    = $clog2(MaxRows + 1);
  localparam int unsigned EW    = ($clog2(MaxStops + 1) > 6) ? $clog2(MaxStops + 1) : 6;
  localparam int unsigned Depth = MaxRows * MaxStops;
  localparam int unsigned AW    = $clog2(Depth);

  logic [15:0]   mem_q [Depth];
  logic [15:0]   rd_data_q;
  logic [15:0]   buf_q [MaxStops];
  logic [5:0]    stop_count_q;
  logic [CW-1:0] row_count_q;
  logic [SW-1:0] row_fill_q, row_fill_d;
  in_item_t      item_q;
  logic [CW-1:0] idx_q, pos_q;
  logic [SW-1:0] stp_q;
  logic [15:0]   res_time_q;
  logic          res_found_q;
  logic [1:0]    res_status_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // effective stop count, 1..MaxStops
  logic [EW-1:0] sc_ext, n_eff, fill_eff, fill_next;
  assign sc_ext = EW'(stop_count_q);
  always_comb begin
    priority if (stop_count_q == 6'd0) n_eff = EW'(1);
    else if (sc_ext > EW'(MaxStops))   n_eff = EW'(MaxStops);
    else                               n_eff = sc_ext;
  end

  assign fill_eff  = (EW'(row_fill_q) >= n_eff) ? '0 : EW'(row_fill_q);
  assign fill_next = fill_eff + EW'(1);
  assign row_fill_d = (fill_next >= n_eff) ? '0 : SW'(fill_next);

  // memory address
  logic [CW-1:0] row_sel;
  logic [AW-1:0] col_sel, addr;
  always_comb begin
    unique case (cmd_i.row_sel)
      ROW_IDX:   row_sel = idx_q;
      ROW_IDXM1: row_sel = idx_q - CW'(1);
      ROW_POS:   row_sel = pos_q;
      default:   row_sel = idx_q;
    endcase
    unique case (cmd_i.col_sel)
      COL_FROM: col_sel = AW'(item_q.from_stop);
      COL_TO:   col_sel = AW'(item_q.to_stop);
      COL_ZERO: col_sel = '0;
      COL_STP:  col_sel = AW'(stp_q);
      default:  col_sel = '0;
    endcase
  end
  assign addr = AW'(row_sel) * AW'(MaxStops) + col_sel;

  logic [15:0] wr_data;
  assign wr_data = cmd_i.wr_buf ? ((EW'(stp_q) < n_eff) ? buf_q[stp_q] : 16'd0)
                                : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.add_time) begin
      buf_q[SW'(fill_eff)] <= item_q.time_value;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q;
    end
    unique case (cmd_i.res_op)
      RES_STATUS: begin
        res_time_q   <= 16'd0;
        res_found_q  <= 1'b0;
        res_status_q <= cmd_i.res_status;
      end
      RES_HIT: begin
        res_time_q   <= rd_data_q;
        res_found_q  <= 1'b1;
        res_status_q <= ST_OK;
      end
      default: ;
    endcase
    unique case (cmd_i.out_op)
      OUT_RES: out_q <= '{result_time: res_time_q, found: res_found_q,
                          status: res_status_q, last: 1'b1};
      OUT_COL: out_q <= '{result_time: rd_data_q, found: 1'b0,
                          status: ST_OK, last: stat_o.idx_at_last};
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= 6'd1;
      row_count_q  <= '0;
      row_fill_q   <= '0;
      idx_q        <= '0;
      stp_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stop_count_q <= cfg_data_i;
        row_fill_q   <= '0;
      end else if (cmd_i.add_time) begin
        row_fill_q <= row_fill_d;
      end
      if (cmd_i.cnt_inc) begin
        row_count_q <= row_count_q + CW'(1);
      end
      unique case (cmd_i.idx_op)
        IDX_ZERO:  idx_q <= '0;
        IDX_INC:   idx_q <= idx_q + CW'(1);
        IDX_DEC:   idx_q <= idx_q - CW'(1);
        IDX_COUNT: idx_q <= row_count_q;
        default:   ;
      endcase
      if (cmd_i.stp_zero) begin
        stp_q <= '0;
      end else if (cmd_i.stp_inc) begin
        stp_q <= stp_q + SW'(1);
      end
      if (cmd_i.out_op != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.mode         = item_q.mode;
    stat_o.bad_col      = EW'(item_q.from_stop) >= n_eff;
    stat_o.bad_find     = (EW'(item_q.from_stop) >= n_eff) ||
                          (EW'(item_q.to_stop) >= n_eff);
    stat_o.empty        = (row_count_q == '0);
    stat_o.full         = (row_count_q >= CW'(MaxRows));
    stat_o.row_done     = (fill_next >= n_eff);
    stat_o.ge_hit       = (rd_data_q >= item_q.time_value);
    stat_o.lt_first     = (rd_data_q < buf_q[0]);
    stat_o.idx_at_count = (idx_q == row_count_q);
    stat_o.idx_at_last  = (idx_q == row_count_q - CW'(1));
    stat_o.idx_at_pos   = (idx_q == pos_q);
    stat_o.stp_end      = (stp_q == SW'(MaxStops - 1));
    stat_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: design/sorted_timetable_search.sv
`default_nettype none
// Operations: add stores a time in the row buffer; a completed row is inserted
//   by scanning for its place, shifting later rows down one and writing the row;
//   column read returns one beat per row; find scans rows until a hit or the last.
// Throughput: one item at a time; the single-port table memory sets the pace.
// Reset: async active low; clears row count, fill count, stop_count to 1.
//   Table contents and row buffer are undefined until written.
// ----------------------------------------------------------------------------
// sorted_timetable_search: sorted timetable with column read and lower bound
// Rows are kept sorted by their first time; find returns the to_stop time of the
// first row whose from_stop time is at least the leave time.
// ----------------------------------------------------------------------------
module sorted_timetable_search
  import sts_pkg::*;
#(
  parameter int unsigned MaxRows  = MAX_ROWS_DEF,
  parameter int unsigned MaxStops = MAX_STOPS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // stop_count register
  input  wire logic       cfg_we_i,
  input  wire logic [5:0] cfg_data_i,
  // input beats
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  // result beats
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accepts a beat only when idle, then walks the table
  sts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table memory (row r, stop s at r*MaxStops+s), buffer and result register
  sts_dpath #(
    .MaxRows  (MaxRows),
    .MaxStops (MaxStops)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
